// ===== sv/mrs_pkg.sv =====
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared types and constants for the mapping record sorter: record layout,
// transaction payloads, function and status codes.
// ----------------------------------------------------------------------------
package mrs_pkg;

   // default number of cells in the sorting row
   localparam int CAPACITY_DEFAULT = 256;

   // largest valid code point (larger values are still sorted by all 21 bits)
   localparam logic [20:0] MAX_CODE_POINT = 21'h10ffff;

   // request function codes
   typedef enum logic {
      FUNC_INSERT = 1'b0,
      FUNC_POP    = 1'b1
   } mrs_func_type;

   // response status codes
   typedef enum logic [1:0] {
      ST_INSERTED = 2'd0,
      ST_POPPED   = 2'd1,
      ST_FULL     = 2'd2,
      ST_EMPTY    = 2'd3
   } mrs_status_type;

   // held count as shown on the response
   typedef logic [8:0] mrs_held_type;

   // one stored record; packed order gives the composite sort key
   typedef struct packed {
      logic [20:0] code_point;
      logic [31:0] byte_seq;
      logic [1:0]  fallback_kind;
   } mrs_rec_type;

   // request transaction payload
   typedef struct packed {
      mrs_func_type func;
      logic [20:0]  code_point;
      logic [31:0]  byte_seq;
      logic [1:0]   fallback_kind;
   } mrs_req_type;

   // response transaction payload
   typedef struct packed {
      mrs_status_type status;
      logic [20:0]    out_code_point;
      logic [31:0]    out_byte_seq;
      logic [1:0]     out_fallback_kind;
      logic           last;
      mrs_held_type   held;
   } mrs_rsp_type;

   // operation broadcast to every cell
   typedef struct packed {
      logic        ins;
      logic        pop;
      mrs_rec_type key;
   } mrs_op_type;

endpackage

// ===== sv/mapping_record_sorter.sv =====
// ----------------------------------------------------------------------------
// mapping_record_sorter
// Sorting store for character-mapping records. Inserts place a record in
// order by code point, byte sequence and fallback kind; pops return the
// smallest record.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req       in         req_valid/req_stall  mrs_req_type (func, record)
//  rsp       out        rsp_valid/rsp_stall  mrs_rsp_type (status, record,
//                                            last, held)
//
//  one transaction per cycle while req_stall is low; the result is registered and appears in the cycle after acceptance
//  every cell compares with the broadcast key and shifts in the same cycle,
//  so an insert or a pop needs no pass along the row, however many records are held
//  reset clears the cell valid bits and the count directly, no clear pass
//  req_stall is high while a result waits in the output register under
//  rsp_stall
// ----------------------------------------------------------------------------
module mapping_record_sorter #(
   parameter int CAPACITY = mrs_pkg::CAPACITY_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  mrs_pkg::mrs_req_type req_data,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output mrs_pkg::mrs_rsp_type rsp_data
);

   localparam int CntW = $clog2(CAPACITY + 1);

   logic                 req_fire;
   logic                 is_full, is_empty;
   logic [CntW-1:0]      count_ff, count_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mrs_pkg::mrs_rsp_type rsp_data_ff, rsp_data_in;
   mrs_pkg::mrs_op_type  op;
   mrs_pkg::mrs_rec_type head_rec;

   // input handshake
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_fire  = req_valid && !req_stall;

   assign is_full  = (count_ff == CntW'(CAPACITY));
   assign is_empty = (count_ff == '0);

   // operation for the cell row
   always_comb begin
      op.ins              = req_fire && (req_data.func == mrs_pkg::FUNC_INSERT) && !is_full;
      op.pop              = req_fire && (req_data.func == mrs_pkg::FUNC_POP) && !is_empty;
      op.key.code_point    = req_data.code_point;
      op.key.byte_seq      = req_data.byte_seq;
      op.key.fallback_kind = req_data.fallback_kind;
   end

   mrs_chain #(
      .CAPACITY (CAPACITY)
   ) u_chain (
      .clock    (clock),
      .reset    (reset),
      .op       (op),
      .head_rec (head_rec)
   );

   // record count
   always_comb begin
      count_in = count_ff;
      if (op.ins) begin
         count_in = count_ff + CntW'(1);
      end else if (op.pop) begin
         count_in = count_ff - CntW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // response contents
   always_comb begin
      rsp_data_in      = '0;
      rsp_data_in.held = mrs_pkg::mrs_held_type'(count_in);
      case (req_data.func)
         mrs_pkg::FUNC_INSERT: begin
            rsp_data_in.status = is_full ? mrs_pkg::ST_FULL : mrs_pkg::ST_INSERTED;
         end
         mrs_pkg::FUNC_POP: begin
            if (is_empty) begin
               rsp_data_in.status = mrs_pkg::ST_EMPTY;
            end else begin
               rsp_data_in.status            = mrs_pkg::ST_POPPED;
               rsp_data_in.out_code_point    = head_rec.code_point;
               rsp_data_in.out_byte_seq      = head_rec.byte_seq;
               rsp_data_in.out_fallback_kind = head_rec.fallback_kind;
               rsp_data_in.last              = (count_ff == CntW'(1));
            end
         end
         default: begin
            rsp_data_in.status = mrs_pkg::ST_EMPTY;
         end
      endcase
   end

   // output register
   assign rsp_valid_in = req_fire || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/mrs_cell.sv =====
// ----------------------------------------------------------------------------
// mrs_cell
// One slot of the sorting row. Holds a record and its valid bit, compares
// the broadcast key against its record and shifts with its neighbors.
// ----------------------------------------------------------------------------
module mrs_cell (
   input  logic                clock,
   input  logic                reset,
   input  mrs_pkg::mrs_op_type op,
   input  logic                left_valid,
   input  logic                left_place,
   input  mrs_pkg::mrs_rec_type left_rec,
   input  logic                right_valid,
   input  mrs_pkg::mrs_rec_type right_rec,
   output logic                valid,
   output logic                place,
   output mrs_pkg::mrs_rec_type rec
);

   logic                 valid_ff, valid_in;
   mrs_pkg::mrs_rec_type rec_ff, rec_in;

   // this slot takes the key or shifts right: empty, or holds a larger record
   assign place = !valid_ff || (rec_ff > op.key);

   // next slot contents
   always_comb begin
      valid_in = valid_ff;
      rec_in   = rec_ff;
      if (op.ins) begin
         valid_in = valid_ff || left_valid;
         if (left_place) begin
            rec_in = left_rec;
         end else if (place) begin
            rec_in = op.key;
         end
      end else if (op.pop) begin
         valid_in = right_valid;
         rec_in   = right_rec;
      end
   end

   // valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // record payload
   always_ff @(posedge clock) begin
      rec_ff <= rec_in;
   end

   assign valid = valid_ff;
   assign rec   = rec_ff;

endmodule

// ===== sv/mrs_chain.sv =====
// ----------------------------------------------------------------------------
// mrs_chain
// Row of sorting cells kept in ascending order. Head cell holds the
// smallest record.
// ----------------------------------------------------------------------------
module mrs_chain #(
   parameter int CAPACITY = mrs_pkg::CAPACITY_DEFAULT
) (
   input  logic                 clock,
   input  logic                 reset,
   input  mrs_pkg::mrs_op_type  op,
   output mrs_pkg::mrs_rec_type head_rec
);

   logic                 valid [CAPACITY];
   logic                 place [CAPACITY];
   mrs_pkg::mrs_rec_type rec   [CAPACITY];

   // cell row with neighbor links
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic                 lv, lp, rv;
      mrs_pkg::mrs_rec_type lr, rr;

      if (i == 0) begin : g_first
         assign lv = 1'b1;
         assign lp = 1'b0;
         assign lr = rec[0];
      end else begin : g_mid
         assign lv = valid[i-1];
         assign lp = place[i-1];
         assign lr = rec[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign rv = 1'b0;
         assign rr = rec[i];
      end else begin : g_inner
         assign rv = valid[i+1];
         assign rr = rec[i+1];
      end

      mrs_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .op          (op),
         .left_valid  (lv),
         .left_place  (lp),
         .left_rec    (lr),
         .right_valid (rv),
         .right_rec   (rr),
         .valid       (valid[i]),
         .place       (place[i]),
         .rec         (rec[i])
      );
   end

   assign head_rec = rec[0];

endmodule

// ===== sv/mrs_checker.sv =====
// ----------------------------------------------------------------------------
// mrs_checker
// Port-level checks of the mapping record sorter, bound to the top level.
// ----------------------------------------------------------------------------
module mrs_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_valid,
   input logic                 req_stall,
   input mrs_pkg::mrs_req_type req_data,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input mrs_pkg::mrs_rsp_type rsp_data
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // every accepted transaction gives a result in the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no response");

   // an empty pop carries no record and reports nothing held
   a_empty_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == mrs_pkg::ST_EMPTY) |->
         (rsp_data.held == '0) && !rsp_data.last && (rsp_data.out_code_point == '0)
         && (rsp_data.out_byte_seq == '0) && (rsp_data.out_fallback_kind == '0))
      else $error("empty pop response not clean");

   // last is only flagged on a pop that leaves nothing held
   a_last_pop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.last |->
         (rsp_data.status == mrs_pkg::ST_POPPED) && (rsp_data.held == '0))
      else $error("last flag on wrong response");

   // a dropped insert carries no record
   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == mrs_pkg::ST_FULL) |->
         !rsp_data.last && (rsp_data.out_code_point == '0)
         && (rsp_data.out_byte_seq == '0) && (rsp_data.out_fallback_kind == '0))
      else $error("full response not clean");

endmodule

bind mapping_record_sorter mrs_checker u_mrs_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
